// ===== sv/maf_pkg.sv =====
// Shared constants, types and command structs for the moving average filter.
package maf_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_W        = 7;
  localparam int POS_W        = $clog2(WINDOW_MAX);
  localparam int LEN_W        = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W        = SAMPLE_W + POS_W;
  localparam int CNT_W        = $clog2(SUM_W);
  localparam int WINDOW_RESET = 8;
  localparam int ADDR_W       = 2;
  localparam int DATA_W       = 32;

  localparam logic [ADDR_W-1:0] ADDR_WINDOW_LENGTH = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIVIDE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic update;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } stat_t;

endpackage

// ===== sv/maf_sample_if.sv =====
// Input channel carrying one signed sample word.
interface maf_sample_if;
  import maf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ===== sv/maf_mean_if.sv =====
// Output channel carrying one signed mean word.
interface maf_mean_if;
  import maf_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean;

  modport source (output valid, output mean, input ready);
  modport sink   (input valid, input mean, output ready);
endinterface

// ===== sv/maf_ctrl.sv =====
// Sequencer for the filter: load, update, divide and result hand-off.
module maf_ctrl import maf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        // hold the quotient until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_load_then_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> cmd_o.update)
    else $error("update did not follow load");

  a_result_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("loaded result not presented");

  a_single_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load, cmd_o.update, cmd_o.div_step, cmd_o.load_out}))
    else $error("more than one command at once");

endmodule

// ===== sv/maf_dp.sv =====
// Datapath: sample ring, running sum, radix-2 divider and output register.
module maf_dp import maf_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic [CFG_W-1:0]           window_length_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  cmd_t                       cmd_i,
  output stat_t                      stat_o,
  output logic signed [SAMPLE_W-1:0] mean_o
);

  logic signed [SAMPLE_W-1:0] ring_mem [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]      valid_q;
  logic signed [SAMPLE_W-1:0] rd_data_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic [POS_W-1:0]           pos_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic [SUM_W-1:0]           quo_q;
  logic [LEN_W-1:0]           rem_q;
  logic [CNT_W-1:0]           cnt_q;
  logic                       neg_q;
  logic signed [SAMPLE_W-1:0] mean_q;

  logic [LEN_W-1:0]           len;
  logic [POS_W-1:0]           rd_addr;
  logic [LEN_W-1:0]           pos_inc;
  logic [POS_W-1:0]           pos_next;
  logic signed [SAMPLE_W-1:0] oldest;
  logic signed [SUM_W-1:0]    sum_new;
  logic [SUM_W-1:0]           sum_mag;
  logic [LEN_W:0]             trial;
  logic [LEN_W:0]             diff;
  logic                       ge;
  logic [SUM_W-1:0]           quo_signed;

  // a zero length acts as one, anything above the ring depth as the depth
  always_comb begin
    if (window_length_i == '0) begin
      len = LEN_W'(1);
    end else if (int'(window_length_i) > WINDOW_MAX) begin
      len = LEN_W'(WINDOW_MAX);
    end else begin
      len = LEN_W'(window_length_i);
    end
  end

  assign rd_addr  = (LEN_W'(pos_q) >= len) ? '0 : pos_q;
  assign pos_inc  = LEN_W'(pos_q) + LEN_W'(1);
  assign pos_next = (pos_inc >= len) ? '0 : POS_W'(pos_inc);

  // entries never written since the last clear read as zero
  assign oldest  = valid_q[pos_q] ? rd_data_q : '0;
  assign sum_new = sum_q - {{POS_W{oldest[SAMPLE_W-1]}}, oldest}
                         + {{POS_W{sample_q[SAMPLE_W-1]}}, sample_q};
  assign sum_mag = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);

  assign trial = {rem_q, quo_q[SUM_W-1]};
  assign diff  = trial - {1'b0, len};
  assign ge    = trial >= {1'b0, len};

  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) ring_mem[pos_q] <= sample_q;
    if (cmd_i.load) rd_data_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
    end else if (clear_i) begin
      valid_q <= '0;
      pos_q   <= '0;
      sum_q   <= '0;
    end else if (cmd_i.load) begin
      pos_q <= rd_addr;
    end else if (cmd_i.update) begin
      valid_q[pos_q] <= 1'b1;
      pos_q          <= pos_next;
      sum_q          <= sum_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) sample_q <= sample_i;
    if (cmd_i.update) begin
      quo_q <= sum_mag;
      rem_q <= '0;
      cnt_q <= '0;
      neg_q <= sum_new[SUM_W-1];
    end else if (cmd_i.div_step) begin
      // shift in one dividend bit, subtract where it fits
      rem_q <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.load_out) mean_q <= quo_signed[SAMPLE_W-1:0];
  end

  assign stat_o.div_last = (cnt_q == CNT_W'(SUM_W - 1));
  assign mean_o          = mean_q;

  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> (LEN_W'(pos_q) < len))
    else $error("ring position outside window");

  a_div_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.update |=> (cnt_q == '0 && rem_q == '0))
    else $error("divider not initialised");

  a_rem_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < len))
    else $error("remainder not below divisor");

endmodule

// ===== sv/moving_average_filter_core.sv =====
// Accepts one sample word per item; load, update and divide steps then form the mean
// with the 22-step restoring divider (one quotient bit a cycle), and the hand-off step
// loads it into the output register. Only after that hand-off is a new sample taken.
// The output register lets the next sample word be taken while a mean waits.
// Reset (async, active low) and every window_length write clear the ring valid bits,
// write position and running sum at once; window_length resets to 8.
module moving_average_filter_core import maf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  maf_sample_if.sink        in_i,
  maf_mean_if.source        out_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [CFG_W-1:0] window_length_q;
  logic             reg_sel;
  logic             cfg_wr;
  cmd_t             cmd;
  stat_t            stat;

  assign reg_sel = (paddr == ADDR_WINDOW_LENGTH);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? DATA_W'(window_length_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_length_q <= CFG_W'(WINDOW_RESET);
    end else if (cfg_wr) begin
      window_length_q <= pwdata[CFG_W-1:0];
    end
  end

  maf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  maf_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clear_i         (cfg_wr),
    .window_length_i (window_length_q),
    .sample_i        (in_i.sample),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .mean_o          (out_o.mean)
  );

endmodule
